[rtl/glal_pkg.sv]
`timescale 1ns / 1ps
// Shared opcodes, register indices, item and request types, and accumulator limits for the logit core.
package glal_pkg;

    localparam logic [1:0] OP_GRAM  = 2'd0;
    localparam logic [1:0] OP_QCODE = 2'd1;
    localparam logic [1:0] OP_KEY   = 2'd2;

    localparam logic [1:0] REG_QNORM  = 2'd0;
    localparam logic [1:0] REG_INVSC  = 2'd1;
    localparam logic [1:0] REG_BLOCKS = 2'd2;

    localparam int ACC_W = 31;
    localparam logic signed [ACC_W-1:0] ACC_MAX = 31'sh3FFF_FFFF;
    localparam logic signed [ACC_W-1:0] ACC_MIN = -31'sh4000_0000;

    localparam logic [15:0] ROUND_HALF = 16'h8000;

    typedef enum logic [1:0] {
        K_GRAM,
        K_QCODE,
        K_KEY
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [15:0]        addr;
        logic signed [23:0] value;
        logic [7:0]         pos;
        logic [7:0]         code;
        logic               code_ok;
        logic [23:0]        knorm;
    } t_item;

    typedef struct packed {
        logic                    start;
        logic signed [ACC_W-1:0] acc;
        logic [23:0]             knorm;
    } t_scale_req;

endpackage

[rtl/glal_front.sv]
`timescale 1ns / 1ps
// Front end: accepts, classifies and filters transactions into a two-entry queue.
module glal_front
    import glal_pkg::*;
#(
    parameter int TABLE_DIM  = 256,
    parameter int MAX_BLOCKS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_opcode,
    input  logic [15:0]        i_table_addr,
    input  logic signed [23:0] i_table_value,
    input  logic [5:0]         i_block_pos,
    input  logic [7:0]         i_code_index,
    input  logic [23:0]        i_key_norm,
    input  logic               i_pop,
    output logic               o_nonempty,
    output t_item              o_item
);

    localparam int GramDepth = TABLE_DIM * TABLE_DIM;

    t_item      r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    t_item      item;
    logic       keep;
    logic       push;

    always_comb begin
        item.addr    = i_table_addr;
        item.value   = i_table_value;
        item.pos     = 8'(i_block_pos);
        item.code    = i_code_index;
        item.code_ok = 9'(i_code_index) < 9'(TABLE_DIM);
        item.knorm   = i_key_norm;
        item.kind    = K_GRAM;
        keep         = 1'b0;
        case (i_opcode)
            OP_GRAM: begin
                item.kind = K_GRAM;
                keep      = 17'(i_table_addr) < 17'(GramDepth);
            end
            OP_QCODE: begin
                item.kind = K_QCODE;
                keep      = 9'(i_block_pos) < 9'(MAX_BLOCKS);
            end
            OP_KEY: begin
                item.kind = K_KEY;
                keep      = 1'b1;
            end
            default: keep = 1'b0;
        endcase
    end

    assign o_stall    = (r_cnt == 2'd2);
    assign push       = i_valid && !o_stall && keep;
    assign o_nonempty = (r_cnt != 2'd0);
    assign o_item     = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= item;
    end

endmodule

[rtl/glal_exec.sv]
`timescale 1ns / 1ps
// Back end: code and gram stores, block counter and saturating accumulator.
module glal_exec
    import glal_pkg::*;
#(
    parameter int TABLE_DIM  = 256,
    parameter int MAX_BLOCKS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_item      i_item,
    input  logic       i_nonempty,
    output logic       o_pop,
    input  logic [6:0] i_block_count,
    input  logic       i_busy,
    output t_scale_req o_req
);

    localparam int GramDepth = TABLE_DIM * TABLE_DIM;
    localparam int GW        = $clog2(GramDepth);
    localparam int QW        = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW        = $clog2(MAX_BLOCKS + 1);
    localparam logic [8:0] MaxB9 = 9'(MAX_BLOCKS);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_GRD  = 4'b0010,
        S_ACC  = 4'b0100,
        S_SEND = 4'b1000
    } t_state;

    logic signed [23:0]      r_gram [GramDepth];
    logic [7:0]              r_qmem [MAX_BLOCKS];

    t_state                  r_state;
    t_state                  n_state;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           n_count;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] n_acc;

    logic [7:0]              r_qdata;
    logic signed [23:0]      r_gdata;
    logic [7:0]              r_code;
    logic                    r_code_ok;
    logic [23:0]             r_knorm;
    logic                    r_ok;

    logic                    gram_we;
    logic                    q_we;
    logic                    key_take;
    logic                    start;
    logic                    qc_ok;
    logic [15:0]             rd_full;
    logic [GW-1:0]           rd_addr;
    logic [8:0]              eff9;
    logic [8:0]              next9;
    logic                    last;
    logic signed [31:0]      sum;
    logic signed [ACC_W-1:0] acc_sat;

    // Gram row comes from the query code of the current block, column from the key code.
    assign qc_ok   = 9'(r_qdata) < 9'(TABLE_DIM);
    assign rd_full = 16'(16'(r_qdata) * 16'(TABLE_DIM)) + 16'(r_code);
    assign rd_addr = (qc_ok && r_code_ok) ? rd_full[GW-1:0] : '0;

    always_comb begin
        if (i_block_count == 7'd0) begin
            eff9 = 9'd1;
        end else if (9'(i_block_count) > MaxB9) begin
            eff9 = MaxB9;
        end else begin
            eff9 = 9'(i_block_count);
        end
    end

    assign next9 = 9'(r_count) + 9'd1;
    assign last  = (next9 >= eff9);

    always_comb begin
        sum = 32'(r_acc) + (r_ok ? 32'(r_gdata) : 32'sd0);
        if (sum > 32'(ACC_MAX)) begin
            acc_sat = ACC_MAX;
        end else if (sum < 32'(ACC_MIN)) begin
            acc_sat = ACC_MIN;
        end else begin
            acc_sat = ACC_W'(sum);
        end
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_acc    = r_acc;
        o_pop    = 1'b0;
        gram_we  = 1'b0;
        q_we     = 1'b0;
        key_take = 1'b0;
        start    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_nonempty) begin
                    o_pop = 1'b1;
                    case (i_item.kind)
                        K_GRAM:  gram_we = 1'b1;
                        K_QCODE: q_we    = 1'b1;
                        K_KEY: begin
                            key_take = 1'b1;
                            n_state  = S_GRD;
                        end
                        default: ;
                    endcase
                end
            end
            S_GRD: n_state = S_ACC;
            S_ACC: begin
                n_acc = acc_sat;
                if (last) begin
                    n_state = S_SEND;
                end else begin
                    n_count = CW'(next9);
                    n_state = S_IDLE;
                end
            end
            S_SEND: begin
                // hold the finished sum until the scaler is free
                if (!i_busy) begin
                    start   = 1'b1;
                    n_acc   = '0;
                    n_count = '0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_acc   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_acc   <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (gram_we) r_gram[i_item.addr[GW-1:0]] <= i_item.value;
        r_gdata <= r_gram[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (q_we) r_qmem[i_item.pos[QW-1:0]] <= i_item.code;
        r_qdata <= r_qmem[r_count[QW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (key_take) begin
            r_code    <= i_item.code;
            r_code_ok <= i_item.code_ok;
            r_knorm   <= i_item.knorm;
        end
        if (r_state == S_GRD) r_ok <= qc_ok && r_code_ok;
    end

    assign o_req.start = start;
    assign o_req.acc   = r_acc;
    assign o_req.knorm = r_knorm;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        9'(r_count) < MaxB9)
        else $error("block counter out of range");

    a_read_then_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_GRD |=> r_state == S_ACC)
        else $error("gram read not followed by accumulate");

    a_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req.start |-> !i_busy)
        else $error("scale request while scaler busy");

    a_clear_after_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req.start |=> (r_acc == '0) && (r_count == '0))
        else $error("key state not cleared after handoff");

endmodule

[rtl/glal_scale.sv]
`timescale 1ns / 1ps
// Norm and scale multiply sequence on one shared multiplier, with saturation and output register.
module glal_scale
    import glal_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_scale_req         i_req,
    output logic               o_busy,
    input  logic [23:0]        i_query_norm,
    input  logic [16:0]        i_inv_scale,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_logit,
    output logic               o_saturated
);

    typedef enum logic [6:0] {
        SC_IDLE = 7'b0000001,
        SC_M1   = 7'b0000010,
        SC_M2L  = 7'b0000100,
        SC_M2H  = 7'b0001000,
        SC_M3L  = 7'b0010000,
        SC_M3H  = 7'b0100000,
        SC_FIN  = 7'b1000000
    } t_sc_state;

    t_sc_state          r_state;
    t_sc_state          n_state;
    logic               r_valid;
    logic               r_neg;
    logic [30:0]        r_mag;
    logic [23:0]        r_knorm;
    logic [49:0]        r_m;
    logic [54:0]        r_plo;
    logic signed [31:0] r_logit;
    logic               r_sat;

    logic [30:0]        mul_a;
    logic [23:0]        mul_b;
    logic [54:0]        prod;
    logic [55:0]        sum1;
    logic [75:0]        sum2;
    logic [75:0]        sum3;
    logic               take;
    logic               fin_go;
    logic               fin_sat;
    logic [31:0]        fin_mag;
    logic [31:0]        fin_logit;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            SC_M1: begin
                mul_a = r_mag;
                mul_b = i_query_norm;
            end
            SC_M2L: begin
                mul_a = 31'(r_m[19:0]);
                mul_b = r_knorm;
            end
            SC_M2H: begin
                mul_a = 31'(r_m[38:20]);
                mul_b = r_knorm;
            end
            SC_M3L: begin
                mul_a = 31'(r_m[23:0]);
                mul_b = 24'(i_inv_scale);
            end
            SC_M3H: begin
                mul_a = 31'(r_m[47:24]);
                mul_b = 24'(i_inv_scale);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = 55'(mul_a) * 55'(mul_b);

    // Round to nearest on the magnitude at every stage; high halves join the stored low half.
    assign sum1 = 56'(prod) + 56'(ROUND_HALF);
    assign sum2 = (76'(prod) << 20) + 76'(r_plo) + 76'(ROUND_HALF);
    assign sum3 = (76'(prod) << 24) + 76'(r_plo) + 76'(ROUND_HALF);

    always_comb begin
        if (r_neg) begin
            fin_sat   = r_m > 50'h0_8000_0000;
            fin_mag   = fin_sat ? 32'h8000_0000 : r_m[31:0];
            fin_logit = 32'(32'd0 - fin_mag);
        end else begin
            fin_sat   = r_m > 50'h0_7FFF_FFFF;
            fin_mag   = fin_sat ? 32'h7FFF_FFFF : r_m[31:0];
            fin_logit = fin_mag;
        end
    end

    assign take   = r_valid && !i_stall;
    assign fin_go = (r_state == SC_FIN) && (!r_valid || take);

    always_comb begin
        n_state = r_state;
        case (r_state)
            SC_IDLE: if (i_req.start) n_state = SC_M1;
            SC_M1:   n_state = SC_M2L;
            SC_M2L:  n_state = SC_M2H;
            SC_M2H:  n_state = SC_M3L;
            SC_M3L:  n_state = SC_M3H;
            SC_M3H:  n_state = SC_FIN;
            SC_FIN:  if (fin_go) n_state = SC_IDLE;
            default: n_state = SC_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SC_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fin_go) begin
                r_valid <= 1'b1;
            end else if (take) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            SC_IDLE: begin
                if (i_req.start) begin
                    r_neg   <= i_req.acc < 0;
                    r_mag   <= (i_req.acc < 0) ? 31'(-i_req.acc) : 31'(i_req.acc);
                    r_knorm <= i_req.knorm;
                end
            end
            SC_M1:   r_m   <= 50'(sum1[55:16]);
            SC_M2L:  r_plo <= prod;
            SC_M2H:  r_m   <= sum2[65:16];
            SC_M3L:  r_plo <= prod;
            SC_M3H:  r_m   <= sum3[65:16];
            SC_FIN: begin
                if (fin_go) begin
                    r_logit <= fin_logit;
                    r_sat   <= fin_sat;
                end
            end
            default: ;
        endcase
    end

    assign o_busy      = (r_state != SC_IDLE);
    assign o_valid     = r_valid;
    assign o_logit     = r_logit;
    assign o_saturated = r_sat;

    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin_go |-> (!r_valid || !i_stall))
        else $error("result register overwritten while held");

    a_fin_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == SC_FIN) && !fin_go |=> r_state == SC_FIN)
        else $error("scaler left final stage without loading result");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> r_state == SC_IDLE)
        else $error("request while sequence in flight");

endmodule

[rtl/gram_lookup_attention_logits_core.sv]
`timescale 1ns / 1ps
// Loads: one load per cycle while no key block is in progress; the back end pops each load
// and writes it to its store. Key blocks: the back end takes no new item until a block has
// passed the dependent query code read and gram table read and been accumulated; on a
// key's last block it adds a handoff state that waits while the scaler is busy. The scaler
// runs its multiply sequence beside the next key and holds its result while output stalls.
// Reset: control, counters, accumulator and config registers reset; stores are not cleared.
module gram_lookup_attention_logits_core
    import glal_pkg::*;
#(
    parameter int TABLE_DIM  = 256,
    parameter int MAX_BLOCKS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_opcode,
    input  logic [15:0]        i_table_addr,
    input  logic signed [23:0] i_table_value,
    input  logic [5:0]         i_block_pos,
    input  logic [7:0]         i_code_index,
    input  logic [23:0]        i_key_norm,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_logit,
    output logic               o_saturated,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [23:0] r_query_norm;
    logic [16:0] r_inv_scale;
    logic [6:0]  r_block_count;
    logic        cfg_we;

    t_item       q_item;
    logic        q_nonempty;
    logic        q_pop;
    t_scale_req  sc_req;
    logic        sc_busy;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query_norm  <= 24'd65536;
            r_inv_scale   <= 17'd65536;
            r_block_count <= 7'd64;
        end else if (cfg_we) begin
            case (paddr[3:2])
                REG_QNORM:  r_query_norm  <= pwdata[23:0];
                REG_INVSC:  r_inv_scale   <= pwdata[16:0];
                REG_BLOCKS: r_block_count <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_QNORM:  prdata = 32'(r_query_norm);
            REG_INVSC:  prdata = 32'(r_inv_scale);
            REG_BLOCKS: prdata = 32'(r_block_count);
            default:    prdata = '0;
        endcase
    end

    glal_front #(
        .TABLE_DIM  (TABLE_DIM),
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_opcode      (i_opcode),
        .i_table_addr  (i_table_addr),
        .i_table_value (i_table_value),
        .i_block_pos   (i_block_pos),
        .i_code_index  (i_code_index),
        .i_key_norm    (i_key_norm),
        .i_pop         (q_pop),
        .o_nonempty    (q_nonempty),
        .o_item        (q_item)
    );

    glal_exec #(
        .TABLE_DIM  (TABLE_DIM),
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_exec (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (q_item),
        .i_nonempty    (q_nonempty),
        .o_pop         (q_pop),
        .i_block_count (r_block_count),
        .i_busy        (sc_busy),
        .o_req         (sc_req)
    );

    glal_scale u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (sc_req),
        .o_busy       (sc_busy),
        .i_query_norm (r_query_norm),
        .i_inv_scale  (r_inv_scale),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_logit      (o_logit),
        .o_saturated  (o_saturated)
    );

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the Gram-table attention logit core.
module testbench
    import glal_pkg::*;
();

    localparam int          GRAM_N        = 256;
    localparam int          MAX_BLK       = 64;
    localparam logic [1:0]  OP_UNUSED     = 2'd3;
    localparam int          SETTLE_CYCLES = 24;
    localparam int          HOLDOFF_CYCLES = 400;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [15:0]        addr;
        logic signed [23:0] value;
        logic [5:0]         pos;
        logic [7:0]         code;
        logic [23:0]        knorm;
    } t_lookup_txn;

    typedef struct packed {
        logic signed [31:0] logit;
        logic               saturated;
    } t_logit_rec;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [1:0]         i_opcode;
    logic [15:0]        i_table_addr;
    logic signed [23:0] i_table_value;
    logic [5:0]         i_block_pos;
    logic [7:0]         i_code_index;
    logic [23:0]        i_key_norm;
    logic               o_valid;
    logic               i_stall;
    logic signed [31:0] o_logit;
    logic               o_saturated;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    // Mirror of the block: stores, key progress and registers
    logic signed [23:0] gram_mirror [0:GRAM_N*GRAM_N-1];
    bit                 gram_written [0:GRAM_N*GRAM_N-1];
    logic [7:0]         qcode_mirror [0:MAX_BLK-1];
    int                 model_block;
    longint             model_acc;
    logic [23:0]        cfg_query_norm;
    logic [16:0]        cfg_inv_scale;
    logic [6:0]         cfg_blocks;

    // Written columns per gram row, used to pick key codes that hit loaded entries
    logic [7:0]         row_cols [0:GRAM_N-1][0:15];
    int                 row_ncols [0:GRAM_N-1];
    int                 loaded_rows [$];

    t_logit_rec         pending_logits [$];
    int                 fail_count;
    int                 idle_pct;
    int                 stall_pct;
    int                 holdoff_requests;
    int                 holdoff_seen;
    int                 holdoff_left;
    int                 setting_index;

    gram_lookup_attention_logits_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_opcode      (i_opcode),
        .i_table_addr  (i_table_addr),
        .i_table_value (i_table_value),
        .i_block_pos   (i_block_pos),
        .i_code_index  (i_code_index),
        .i_key_norm    (i_key_norm),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_logit       (o_logit),
        .o_saturated   (o_saturated),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #2 i_clk = ~i_clk;

    // Advance the mirror by one accepted transaction and queue the logit it yields
    function automatic void advance_logit_model(t_lookup_txn t);
        logic [7:0]      qc;
        int              row;
        int              eff;
        longint          entry;
        longint unsigned mag;
        longint unsigned m;
        bit              neg;
        t_logit_rec      r;
        case (t.opcode)
            OP_GRAM: begin
                gram_mirror[t.addr] = t.value;
                if (!gram_written[t.addr]) begin
                    gram_written[t.addr] = 1'b1;
                    row = int'(t.addr[15:8]);
                    if (row_ncols[row] == 0) loaded_rows.push_back(row);
                    if (row_ncols[row] < 16) begin
                        row_cols[row][row_ncols[row]] = t.addr[7:0];
                        row_ncols[row]++;
                    end
                end
            end
            OP_QCODE: begin
                qcode_mirror[t.pos] = t.code;
            end
            OP_KEY: begin
                qc = qcode_mirror[model_block];
                entry = longint'(gram_mirror[{qc, t.code}]);
                model_acc = model_acc + entry;
                if (model_acc > ACC_MAX) model_acc = ACC_MAX;
                if (model_acc < ACC_MIN) model_acc = ACC_MIN;
                model_block++;
                eff = (cfg_blocks == 7'd0) ? 1 :
                      (int'(cfg_blocks) > MAX_BLK) ? MAX_BLK : int'(cfg_blocks);
                if (model_block >= eff) begin
                    neg = model_acc < 0;
                    mag = neg ? -model_acc : model_acc;
                    // Round each stage to nearest on the magnitude
                    m = (mag * 64'(cfg_query_norm) + 64'd32768) >> 16;
                    m = (m * 64'(t.knorm) + 64'd32768) >> 16;
                    m = (m * 64'(cfg_inv_scale) + 64'd32768) >> 16;
                    r.saturated = 1'b0;
                    if (neg && m > 64'h8000_0000) begin
                        m = 64'h8000_0000;
                        r.saturated = 1'b1;
                    end else if (!neg && m > 64'h7FFF_FFFF) begin
                        m = 64'h7FFF_FFFF;
                        r.saturated = 1'b1;
                    end
                    r.logit = neg ? -m[31:0] : m[31:0];
                    pending_logits.push_back(r);
                    model_block = 0;
                    model_acc = 0;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic logic [7:0] pick_key_code();
        int row;
        row = int'(qcode_mirror[model_block]);
        return row_cols[row][$urandom_range(0, row_ncols[row] - 1)];
    endfunction

    function automatic logic [23:0] rand_norm();
        return 24'($urandom & ((32'd1 << $urandom_range(1, 24)) - 32'd1));
    endfunction

    function automatic logic signed [23:0] rand_gram_value();
        logic signed [23:0] v;
        v = 24'($urandom);
        if ($urandom_range(0, 1)) v = v >>> $urandom_range(0, 23);
        return v;
    endfunction

    function automatic t_lookup_txn filler_txn(logic [1:0] opcode);
        t_lookup_txn t;
        t.opcode = opcode;
        t.addr   = 16'($urandom);
        t.value  = 24'($urandom);
        t.pos    = 6'($urandom);
        t.code   = 8'($urandom);
        t.knorm  = 24'($urandom);
        return t;
    endfunction

    // Offer one transaction, hold it until accepted, then update the mirror
    task automatic send_txn(t_lookup_txn t);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < idle_pct) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_opcode      <= t.opcode;
        i_table_addr  <= t.addr;
        i_table_value <= t.value;
        i_block_pos   <= t.pos;
        i_code_index  <= t.code;
        i_key_norm    <= t.knorm;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        advance_logit_model(t);
    endtask

    task automatic send_gram(logic [15:0] addr, logic signed [23:0] value);
        t_lookup_txn t;
        t = filler_txn(OP_GRAM);
        t.addr = addr;
        t.value = value;
        send_txn(t);
    endtask

    task automatic send_qcode(logic [5:0] pos, logic [7:0] code);
        t_lookup_txn t;
        t = filler_txn(OP_QCODE);
        t.pos = pos;
        t.code = code;
        send_txn(t);
    endtask

    task automatic send_key(logic [7:0] code, logic [23:0] knorm);
        t_lookup_txn t;
        t = filler_txn(OP_KEY);
        t.code = code;
        t.knorm = knorm;
        send_txn(t);
    endtask

    task automatic write_register(logic [1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_QNORM:  cfg_query_norm = value[23:0];
            REG_INVSC:  cfg_inv_scale = value[16:0];
            REG_BLOCKS: cfg_blocks = value[6:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Drop valid, drain every expected logit, then let the pipeline empty
    task automatic settle_block();
        i_valid <= 1'b0;
        while (pending_logits.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_table_setup();
        logic [7:0] rows [0:7];
        rows[0] = 8'd0;
        rows[1] = 8'd255;
        for (int i = 2; i < 8; i++) rows[i] = 8'($urandom_range(1, 254));
        for (int i = 0; i < 8; i++) begin
            send_gram({rows[i], 8'd0}, rand_gram_value());
            send_gram({rows[i], 8'd255}, rand_gram_value());
            repeat (3) send_gram({rows[i], 8'($urandom)}, rand_gram_value());
        end
        for (int p = 0; p < MAX_BLK; p++) begin
            if (p == 0) send_qcode(6'(p), 8'd0);
            else if (p == MAX_BLK - 1) send_qcode(6'(p), 8'd255);
            else send_qcode(6'(p), 8'(loaded_rows[$urandom_range(0, loaded_rows.size() - 1)]));
        end
    endtask

    // One full key under the registers as they come out of reset
    task automatic test_reset_defaults();
        repeat (MAX_BLK) send_key(pick_key_code(), rand_norm());
    endtask

    task automatic test_directed_cases();
        settle_block();
        write_register(REG_BLOCKS, 32'd1);
        write_register(REG_QNORM, 32'hFF_FFFF);
        write_register(REG_INVSC, 32'd65536);
        send_gram(16'h0001, 24'sh7F_FFFF);
        send_gram(16'h0002, 24'sh80_0000);
        send_gram(16'h0003, 24'sd1);
        send_gram(16'h0004, -24'sd1);
        send_gram(16'h0005, 24'sd0);
        send_qcode(6'd0, 8'd0);
        // clip both ways, then a zero key norm
        send_key(8'd1, 24'hFF_FFFF);
        send_key(8'd2, 24'hFF_FFFF);
        send_key(8'd2, 24'd0);
        send_txn(filler_txn(OP_UNUSED));
        // half-way ties round away from zero
        settle_block();
        write_register(REG_QNORM, 32'd32768);
        send_key(8'd3, 24'd65536);
        send_key(8'd4, 24'd65536);
        send_key(8'd5, 24'hFF_FFFF);
        settle_block();
        write_register(REG_INVSC, 32'd0);
        send_key(8'd1, 24'hFF_FFFF);
        // block count of zero acts as one
        settle_block();
        write_register(REG_INVSC, 32'd65536);
        write_register(REG_BLOCKS, 32'd0);
        send_key(8'd1, 24'd65536);
        send_key(8'd4, 24'd65536);
        // lower the block count with a key half done
        settle_block();
        write_register(REG_BLOCKS, 32'd4);
        send_key(pick_key_code(), rand_norm());
        send_key(pick_key_code(), rand_norm());
        settle_block();
        write_register(REG_BLOCKS, 32'd2);
        send_key(pick_key_code(), rand_norm());
        // loads landing in the middle of a key
        settle_block();
        write_register(REG_BLOCKS, 32'd3);
        send_key(pick_key_code(), rand_norm());
        send_gram({qcode_mirror[1], 8'd7}, rand_gram_value());
        send_key(8'd7, rand_norm());
        send_qcode(6'd2, 8'd0);
        send_key(pick_key_code(), rand_norm());
    endtask

    task automatic test_backpressure();
        settle_block();
        write_register(REG_BLOCKS, 32'd1);
        idle_pct = 0;
        stall_pct = 0;
        holdoff_requests++;
        repeat (80) send_key(pick_key_code(), rand_norm());
    endtask

    task automatic test_pause_until_drained();
        repeat (20) send_key(pick_key_code(), rand_norm());
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_logits.size() != 0);
        repeat (20) send_key(pick_key_code(), rand_norm());
    endtask

    task automatic test_random_traffic(int sender_idle, int receiver_stall);
        int         sel;
        int         r;
        logic [7:0] row;
        int         bc_choices [0:7];
        bc_choices = '{0, 1, 2, 3, 5, 64, 127, 4};
        idle_pct = sender_idle;
        stall_pct = receiver_stall;
        for (int s = 0; s < 4; s++) begin
            settle_block();
            r = $urandom_range(0, 99);
            write_register(REG_QNORM,
                           (r < 12) ? 32'd0 : (r < 24) ? 32'hFF_FFFF : 32'(rand_norm()));
            r = $urandom_range(0, 99);
            write_register(REG_INVSC,
                           (r < 12) ? 32'd0 : (r < 30) ? 32'd65536 : $urandom_range(0, 65536));
            write_register(REG_BLOCKS, 32'(bc_choices[setting_index % 8]));
            setting_index++;
            repeat (70) begin
                sel = $urandom_range(0, 99);
                if (sel < 70) begin
                    send_key(pick_key_code(), rand_norm());
                end else if (sel < 86) begin
                    row = $urandom_range(0, 1) ?
                          8'(loaded_rows[$urandom_range(0, loaded_rows.size() - 1)]) :
                          8'($urandom);
                    send_gram({row, 8'($urandom)}, rand_gram_value());
                end else if (sel < 96) begin
                    send_qcode(6'($urandom_range(0, MAX_BLK - 1)),
                               8'(loaded_rows[$urandom_range(0, loaded_rows.size() - 1)]));
                end else begin
                    send_txn(filler_txn(OP_UNUSED));
                end
            end
        end
    endtask

    // Receiver side: random stalls plus an occasional long hold-off
    always @(posedge i_clk) begin
        if (holdoff_seen != holdoff_requests) begin
            holdoff_seen = holdoff_requests;
            holdoff_left = HOLDOFF_CYCLES;
        end
        if (holdoff_left > 0) begin
            holdoff_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_logits
        t_logit_rec want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_logits.size() == 0) begin
                if (fail_count < 10)
                    $display("unexpected logit %0d saturated %0b at %0t",
                             o_logit, o_saturated, $time);
                fail_count++;
            end else begin
                want = pending_logits.pop_front();
                if (o_logit !== want.logit || o_saturated !== want.saturated) begin
                    if (fail_count < 10)
                        $display("logit mismatch at %0t: expected %0d/%0b, got %0d/%0b",
                                 $time, want.logit, want.saturated, o_logit, o_saturated);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_stall       = 1'b0;
        i_opcode      = OP_GRAM;
        i_table_addr  = '0;
        i_table_value = '0;
        i_block_pos   = '0;
        i_code_index  = '0;
        i_key_norm    = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        fail_count    = 0;
        idle_pct      = 0;
        stall_pct     = 0;
        holdoff_requests = 0;
        holdoff_seen  = 0;
        holdoff_left  = 0;
        setting_index = 0;
        model_block   = 0;
        model_acc     = 0;
        cfg_query_norm = 24'd65536;
        cfg_inv_scale = 17'd65536;
        cfg_blocks    = 7'd64;
        for (int i = 0; i < GRAM_N; i++) row_ncols[i] = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_table_setup();
        test_reset_defaults();
        test_directed_cases();
        test_backpressure();
        test_pause_until_drained();
        test_random_traffic(0, 0);
        test_random_traffic(76, 0);
        test_random_traffic(0, 76);
        test_random_traffic(31, 31);

        settle_block();
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/glal_pkg.sv
rtl/glal_front.sv
rtl/glal_exec.sv
rtl/glal_scale.sv
rtl/gram_lookup_attention_logits_core.sv
sim/testbench.sv
